@@ src/sab_pkg.sv @@
`default_nettype none

package sab_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SPLAT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned IN_DATA_W = 120;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned ACC_W     = 24;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned INDEX_W   = 17;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 16;
  localparam int unsigned MUL_B_W = 31;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Kernel weights with 15 fraction bits.
  localparam logic [MUL_B_W-1:0] K_CENTER = 31'd27853;
  localparam logic [MUL_B_W-1:0] K_SIDE   = 31'd9830;

  localparam logic [2:0] NUM_TAPS = 3'd5;
  localparam logic [2:0] LAST_TAP = 3'd4;

  localparam logic [ACC_W-1:0] ACC_MAX = 24'hFFFFFF;

  // Tap order: center, right, left, below, above.
  // The offset holds the tap shift in 1/64 pixel plus one half for rounding.
  function automatic logic signed [17:0] tap_off_x(input logic [2:0] tap);
    logic signed [17:0] off;
    case (tap)
      3'd1:    off = 18'sd96;
      3'd2:    off = -18'sd32;
      default: off = 18'sd32;
    endcase
    return off;
  endfunction

  function automatic logic signed [17:0] tap_off_y(input logic [2:0] tap);
    logic signed [17:0] off;
    case (tap)
      3'd3:    off = 18'sd96;
      3'd4:    off = -18'sd32;
      default: off = 18'sd32;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

@@ src/splat_accumulation_buffer.sv @@
`default_nettype none

// Channel  Direction  tdata                                   tuser
// s_axis   in         pos_x pos_y red green blue weight idx   op
// m_axis   out        out_red out_green out_blue              -
//
// A write item is stored when it is taken. A read item reads the memory, then loads
// the output register. A splat item computes the two kernel weights and then visits
// its five taps in order: each tap in the buffer runs one read-modify-write
// of the single-port accumulator memory through the one shared multiplier.
// Reset clears only the control state; the accumulators hold garbage until
// written. A stalled result waits in the output register; writes and splats are
// taken meanwhile, but a read item holds the input until that register is free.
module splat_accumulation_buffer #(
  parameter int unsigned BUF_WIDTH  = 320,
  parameter int unsigned BUF_HEIGHT = 240
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // pos_x[15:0] pos_y[31:16] red[47:32] green[63:48] blue[79:64]
  // weight[95:80] pixel_index[112:96], zeros above
  input  wire logic [sab_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // op[1:0]
  input  wire logic [sab_pkg::OP_W-1:0]          s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // out_red[7:0] out_green[15:8] out_blue[23:16]
  output logic [sab_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o
);
  import sab_pkg::*;

  localparam int unsigned NPIX   = BUF_WIDTH * BUF_HEIGHT;
  localparam int unsigned AW     = $clog2(NPIX);
  localparam int unsigned WORD_W = 3 * ACC_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_K0     = 4'd1;
  localparam logic [3:0] ST_K1     = 4'd2;
  localparam logic [3:0] ST_ADDR   = 4'd3;
  localparam logic [3:0] ST_RD     = 4'd4;
  localparam logic [3:0] ST_R      = 4'd5;
  localparam logic [3:0] ST_G      = 4'd6;
  localparam logic [3:0] ST_B      = 4'd7;
  localparam logic [3:0] ST_RDOUT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [2:0] tap_q, tap_d;
  logic       m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;

  // Captured item.
  logic [POS_W-1:0]   px_q, py_q;
  logic [COLOR_W-1:0] r_q, g_q, b_q, w_q;
  logic               oor_q;

  logic [MUL_B_W-1:0] wkc_q, wks_q;
  logic [PROD_W-1:0]  prod_q;
  logic [11:0]        x_q;
  logic [AW-1:0]      addr_q;
  logic [ACC_W-1:0]   acc_r_q, acc_g_q;

  logic [WORD_W-1:0]  mem [NPIX];
  logic [WORD_W-1:0]  rd_q;

  // Input fields.
  logic [POS_W-1:0]   in_px, in_py;
  logic [COLOR_W-1:0] in_r, in_g, in_b, in_w;
  logic [INDEX_W-1:0] in_idx;
  logic               in_acc, idx_ok;

  assign in_px  = s_axis_tdata_i[15:0];
  assign in_py  = s_axis_tdata_i[31:16];
  assign in_r   = s_axis_tdata_i[47:32];
  assign in_g   = s_axis_tdata_i[63:48];
  assign in_b   = s_axis_tdata_i[79:64];
  assign in_w   = s_axis_tdata_i[95:80];
  assign in_idx = s_axis_tdata_i[112:96];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_ok = (21'(in_idx) < 21'(NPIX));

  // Tap coordinates.
  logic signed [17:0] xs, ys;
  logic [11:0]        xu, yu;
  logic               tap_in;

  always_comb begin
    xs = $signed({{2{px_q[POS_W-1]}}, px_q}) + tap_off_x(tap_q);
    ys = $signed({{2{py_q[POS_W-1]}}, py_q}) + tap_off_y(tap_q);
    xu = xs[17:6];
    yu = ys[17:6];
    tap_in = !xs[17] && !ys[17] && (xu < 12'(BUF_WIDTH)) && (yu < 12'(BUF_HEIGHT));
  end

  // Shared multiplier.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b, wk;

  assign wk = (tap_q == 3'd0) ? wkc_q : wks_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_K0: begin
        mul_a = w_q;
        mul_b = K_CENTER;
      end
      ST_K1: begin
        mul_a = w_q;
        mul_b = K_SIDE;
      end
      ST_ADDR: begin
        mul_a = MUL_A_W'(yu);
        mul_b = MUL_B_W'(BUF_WIDTH);
      end
      ST_RD: begin
        mul_a = r_q;
        mul_b = wk;
      end
      ST_R: begin
        mul_a = g_q;
        mul_b = wk;
      end
      ST_G: begin
        mul_a = b_q;
        mul_b = wk;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounded contribution and saturating sum for the color in flight.
  logic [PROD_W:0]  rnd_sum;
  logic [17:0]      add_amt;
  logic [ACC_W-1:0] cur_acc;
  logic [ACC_W:0]   sum_raw;
  logic [ACC_W-1:0] sum_sat;

  always_comb begin
    rnd_sum = {1'b0, prod_q} + (PROD_W + 1)'(1 << 29);
    add_amt = rnd_sum[PROD_W:30];
    case (state_q)
      ST_G:    cur_acc = rd_q[2*ACC_W-1:ACC_W];
      ST_B:    cur_acc = rd_q[3*ACC_W-1:2*ACC_W];
      default: cur_acc = rd_q[ACC_W-1:0];
    endcase
    sum_raw = {1'b0, cur_acc} + (ACC_W + 1)'(add_amt);
    sum_sat = sum_raw[ACC_W] ? ACC_MAX : sum_raw[ACC_W-1:0];
  end

  // Memory port control.
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     tap_addr;

  assign tap_addr = prod_q[AW-1:0] + AW'(x_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AW'(in_idx);
    mem_wdata = {ACC_W'(in_b), ACC_W'(in_g), ACC_W'(in_r)};
    if (state_q == ST_IDLE) begin
      mem_we = in_acc && (s_axis_tuser_i == OP_WRITE) && idx_ok;
      mem_re = in_acc && (s_axis_tuser_i == OP_READ) && idx_ok;
    end else if (state_q == ST_RD) begin
      mem_re   = 1'b1;
      mem_addr = tap_addr;
    end else if (state_q == ST_B) begin
      mem_we    = 1'b1;
      mem_addr  = addr_q;
      mem_wdata = {sum_sat, acc_g_q, acc_r_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Read result to bytes: floor(acc * 255 / 32768), clamped.
  function automatic logic [7:0] to_byte(input logic [ACC_W-1:0] acc);
    logic [31:0] p;
    p = {acc, 8'd0} - 32'(acc);
    return (|p[31:23]) ? 8'hFF : p[22:15];
  endfunction

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser_i == OP_SPLAT) begin
          state_d = ST_K0;
        end else if (in_acc && s_axis_tuser_i == OP_READ) begin
          state_d = ST_RDOUT;
        end
      end
      ST_K0: state_d = ST_K1;
      ST_K1: begin
        state_d = ST_ADDR;
        tap_d   = 3'd0;
      end
      ST_ADDR: begin
        if (tap_in) begin
          state_d = ST_RD;
        end else if (tap_q == LAST_TAP) begin
          state_d = ST_IDLE;
        end else begin
          tap_d = tap_q + 3'd1;
        end
      end
      ST_RD: state_d = ST_R;
      ST_R:  state_d = ST_G;
      ST_G:  state_d = ST_B;
      ST_B: begin
        if (tap_q == LAST_TAP) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_ADDR;
          tap_d   = tap_q + 3'd1;
        end
      end
      ST_RDOUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_q     <= 3'd0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_q     <= tap_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a * mul_b);
    if (in_acc) begin
      px_q  <= in_px;
      py_q  <= in_py;
      r_q   <= in_r;
      g_q   <= in_g;
      b_q   <= in_b;
      w_q   <= in_w;
      oor_q <= !idx_ok;
    end
    if (state_q == ST_K1) begin
      wkc_q <= prod_q[MUL_B_W-1:0];
    end
    if (state_q == ST_ADDR) begin
      x_q <= xu;
      if (tap_q == 3'd0) begin
        wks_q <= prod_q[MUL_B_W-1:0];
      end
    end
    if (state_q == ST_RD) begin
      addr_q <= tap_addr;
    end
    if (state_q == ST_R) begin
      acc_r_q <= sum_sat;
    end
    if (state_q == ST_G) begin
      acc_g_q <= sum_sat;
    end
    if (state_q == ST_RDOUT && out_free) begin
      if (oor_q) begin
        m_data_q <= '0;
      end else begin
        m_data_q <= {to_byte(rd_q[3*ACC_W-1:2*ACC_W]), to_byte(rd_q[2*ACC_W-1:ACC_W]),
                     to_byte(rd_q[ACC_W-1:0])};
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef NO_ASSERTIONS
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_q <= LAST_TAP)
    else $error("tap counter out of range");

  a_busy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !s_axis_tready_o) |-> (state_q == ST_B))
    else $error("memory written outside a tap write-back");

  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == OP_READ) |=> (state_q == ST_RDOUT))
    else $error("read item did not enter the result state");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_RDOUT))
    else $error("result raised without a read item");
`endif

endmodule

`default_nettype wire
